@@ sv/prt_pkg.sv @@
// Package for the plane rigid transform: payload and sideband types,
// register map constants, saturation and multiply helpers.
// No dependencies.
`default_nettype none

package prt_pkg;

   localparam int DATA_WIDTH      = 32;
   localparam int Q_SHIFT         = 16;
   localparam int COEF_WIDTH_DEF  = 32;
   localparam int REG_COUNT       = 8;
   localparam int REG_SEL_WIDTH   = 3;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int SQRT_STAGES     = 32;
   localparam int DIV_STAGES      = 17;

   localparam logic [63:0] REG_RESET [REG_COUNT] = '{
      64'h0000_0001_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   typedef struct packed {
      logic signed [31:0] plane_a;
      logic signed [31:0] plane_b;
      logic signed [31:0] plane_c;
      logic signed [31:0] plane_d;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_a;
      logic signed [31:0] out_b;
      logic signed [31:0] out_c;
      logic signed [31:0] out_d;
      logic               zero_normal;
      logic               saturated;
   } rsp_type;

   // values that ride along the sqrt and divide pipelines
   typedef struct packed {
      logic [3:0][31:0] td;
      logic [3:0][31:0] tp;
      logic             sat;
      logic             zero;
   } side_type;

   function automatic logic ovf32(input logic signed [65:0] v);
      return (v > SAT_MAX) || (v < SAT_MIN);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7fff_ffff;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] smul(input logic signed [31:0] x,
                                               input logic signed [31:0] y);
      return 64'(x) * 64'(y);
   endfunction

endpackage

`default_nettype wire

@@ sv/prt_xform.sv @@
// Matrix stages: point scaling, both matrix products and squared length.
// Four register stages. Depends on prt_pkg.
`default_nettype none

module prt_xform #(
   parameter int COEF_WIDTH = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 en,
   input  wire                                 in_valid,
   input  prt_pkg::req_type                    in_data,
   input  wire  [3:0][3:0][COEF_WIDTH-1:0]     coef,
   output logic                                out_valid,
   output logic [63:0]                         out_len2,
   output prt_pkg::side_type                   out_side
);
   import prt_pkg::*;

   logic signed [31:0] c32 [4][4];
   logic signed [31:0] dir [3];

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [63:0] pd_in [3], pd_ff [3];
   logic signed [63:0] pdir_in [4][3], pdir_ff [4][3];
   logic signed [31:0] pt_in [3], pt_ff [3];
   logic signed [31:0] td_in [4], td_ff [4], td3_ff [4];
   logic               sat2_in, sat2_ff, sat3_ff;
   logic signed [63:0] ptp_in [4][4], ptp_ff [4][4];
   logic signed [63:0] sq_in [3], sq_ff [3];
   logic [63:0]        len2_in, len2_ff;
   side_type           side_in, side_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 4; k++) begin
            c32[r][k] = 32'(signed'(coef[r][k]));
         end
      end
      dir[0] = in_data.plane_a;
      dir[1] = in_data.plane_b;
      dir[2] = in_data.plane_c;
   end

   // stage 1: raw products
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pd_in[k] = smul(in_data.plane_d, dir[k]);
         for (int r = 0; r < 4; r++) begin
            pdir_in[r][k] = smul(c32[r][k], dir[k]);
         end
      end
   end

   // stage 2: point components and transformed direction
   always_comb begin
      logic signed [65:0] s;
      sat2_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         s = (-66'(pd_ff[k])) >>> Q_SHIFT;
         pt_in[k] = sat32(s);
         sat2_in = sat2_in | ovf32(s);
      end
      for (int r = 0; r < 4; r++) begin
         s = (66'(pdir_ff[r][0]) + 66'(pdir_ff[r][1]) + 66'(pdir_ff[r][2])) >>> Q_SHIFT;
         td_in[r] = sat32(s);
         sat2_in = sat2_in | ovf32(s);
      end
   end

   // stage 3: point products and squares
   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int k = 0; k < 3; k++) begin
            ptp_in[r][k] = smul(c32[r][k], pt_ff[k]);
         end
         ptp_in[r][3] = 64'(c32[r][3]) <<< Q_SHIFT;
      end
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = smul(td_ff[k], td_ff[k]);
      end
   end

   // stage 4: transformed point and squared length
   always_comb begin
      logic signed [65:0] s;
      side_in.sat = sat3_ff;
      for (int r = 0; r < 4; r++) begin
         s = (66'(ptp_ff[r][0]) + 66'(ptp_ff[r][1]) + 66'(ptp_ff[r][2])
              + 66'(ptp_ff[r][3])) >>> Q_SHIFT;
         side_in.tp[r] = sat32(s);
         side_in.td[r] = td3_ff[r];
         side_in.sat = side_in.sat | ovf32(s);
      end
      len2_in = $unsigned(sq_ff[0]) + $unsigned(sq_ff[1]) + $unsigned(sq_ff[2]);
      side_in.zero = (len2_in == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pd_ff   <= pd_in;
         pdir_ff <= pdir_in;
         pt_ff   <= pt_in;
         td_ff   <= td_in;
         sat2_ff <= sat2_in;
         ptp_ff  <= ptp_in;
         sq_ff   <= sq_in;
         td3_ff  <= td_ff;
         sat3_ff <= sat2_ff;
         len2_ff <= len2_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_len2  = len2_ff;
   assign out_side  = side_ff;

endmodule

`default_nettype wire

@@ sv/prt_sqrt.sv @@
// Integer square root of the squared normal length, one result bit per stage.
// Depends on prt_pkg.
`default_nettype none

module prt_sqrt (
   input  wire               clock,
   input  wire               reset,
   input  wire               en,
   input  wire               in_valid,
   input  wire  [63:0]       in_len2,
   input  prt_pkg::side_type in_side,
   output logic              out_valid,
   output logic [31:0]       out_len,
   output prt_pkg::side_type out_side
);
   import prt_pkg::*;

   logic [SQRT_STAGES-1:0] valid_ff;
   logic [63:0]            rem_in [SQRT_STAGES], rem_ff [SQRT_STAGES];
   logic [64:0]            root_in [SQRT_STAGES], root_ff [SQRT_STAGES];
   side_type               side_ff [SQRT_STAGES];

   always_comb begin
      logic [63:0] rp;
      logic [64:0] qp, trial;
      for (int j = 0; j < SQRT_STAGES; j++) begin
         if (j == 0) begin
            rp = in_len2;
            qp = '0;
         end else begin
            rp = rem_ff[j-1];
            qp = root_ff[j-1];
         end
         trial = qp + (65'd1 << (2 * (SQRT_STAGES - 1 - j)));
         if ({1'b0, rp} >= trial) begin
            rem_in[j]  = 64'({1'b0, rp} - trial);
            root_in[j] = (qp >> 1) + (65'd1 << (2 * (SQRT_STAGES - 1 - j)));
         end else begin
            rem_in[j]  = rp;
            root_in[j] = qp >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[SQRT_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff[0] <= in_side;
         for (int j = 1; j < SQRT_STAGES; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_len   = root_ff[SQRT_STAGES-1][31:0];
   assign out_side  = side_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

@@ sv/prt_div.sv @@
// Normalizing divide: |td| * 2^16 / len for three lanes, one quotient bit
// per stage. Depends on prt_pkg.
`default_nettype none

module prt_div (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     en,
   input  wire                     in_valid,
   input  wire  [31:0]             in_len,
   input  prt_pkg::side_type       in_side,
   output logic                    out_valid,
   output logic [2:0][16:0]        out_quot,
   output prt_pkg::side_type       out_side
);
   import prt_pkg::*;

   logic [DIV_STAGES-1:0] valid_ff;
   logic [47:0]           rem_in [DIV_STAGES][3], rem_ff [DIV_STAGES][3];
   logic [16:0]           q_in [DIV_STAGES][3], q_ff [DIV_STAGES][3];
   logic [31:0]           len_ff [DIV_STAGES];
   side_type              side_ff [DIV_STAGES];

   always_comb begin
      logic [47:0]        rp;
      logic [16:0]        qp;
      logic [31:0]        lp;
      logic [48:0]        dv;
      logic signed [31:0] t;
      for (int j = 0; j < DIV_STAGES; j++) begin
         for (int l = 0; l < 3; l++) begin
            if (j == 0) begin
               t  = in_side.td[l];
               rp = {(t < 0) ? 32'(-t) : 32'(t), 16'b0};
               qp = '0;
               lp = in_len;
            end else begin
               rp = rem_ff[j-1][l];
               qp = q_ff[j-1][l];
               lp = len_ff[j-1];
            end
            dv = 49'(lp) << (DIV_STAGES - 1 - j);
            if ({1'b0, rp} >= dv) begin
               rem_in[j][l] = 48'({1'b0, rp} - dv);
               q_in[j][l]   = qp | (17'd1 << (DIV_STAGES - 1 - j));
            end else begin
               rem_in[j][l] = rp;
               q_in[j][l]   = qp;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DIV_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         len_ff[0]  <= in_len;
         side_ff[0] <= in_side;
         for (int j = 1; j < DIV_STAGES; j++) begin
            len_ff[j]  <= len_ff[j-1];
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         out_quot[l] = q_ff[DIV_STAGES-1][l];
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

@@ sv/prt_out.sv @@
// Output stages: signed normal, final dot product, offset, and the
// output register with its skid slot. Depends on prt_pkg.
`default_nettype none

module prt_out (
   input  wire                clock,
   input  wire                reset,
   output logic               en,
   input  wire                in_valid,
   input  wire  [2:0][16:0]   in_quot,
   input  prt_pkg::side_type  in_side,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output prt_pkg::rsp_type   rsp_data
);
   import prt_pkg::*;

   logic               va_ff, vb_ff;
   logic signed [31:0] n_in [4], n_ff [4], nb_ff [3];
   logic [3:0][31:0]   tpa_ff;
   logic               sata_ff, zeroa_ff, satb_ff, zerob_ff;
   logic signed [63:0] prod_in [4], prod_ff [4];
   rsp_type            item_in, out_ff, skid_ff;
   logic               out_valid_ff, skid_valid_ff;
   logic               push, take;

   assign en = !skid_valid_ff;

   // stage A: pick the normal (unnormalized when its length is zero)
   always_comb begin
      logic signed [31:0] qs;
      for (int k = 0; k < 3; k++) begin
         qs = 32'(signed'({1'b0, in_quot[k]}));
         if (in_side.zero) begin
            n_in[k] = in_side.td[k];
         end else if ($signed(in_side.td[k]) < 0) begin
            n_in[k] = -qs;
         end else begin
            n_in[k] = qs;
         end
      end
      n_in[3] = in_side.td[3];
   end

   // stage B: dot products
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod_in[k] = smul(n_ff[k], $signed(tpa_ff[k]));
      end
   end

   // stage C: sum, negate, clamp
   always_comb begin
      logic signed [65:0] s;
      s = -((66'(prod_ff[0]) + 66'(prod_ff[1]) + 66'(prod_ff[2])
             + 66'(prod_ff[3])) >>> Q_SHIFT);
      item_in.out_a       = nb_ff[0];
      item_in.out_b       = nb_ff[1];
      item_in.out_c       = nb_ff[2];
      item_in.out_d       = sat32(s);
      item_in.zero_normal = zerob_ff;
      item_in.saturated   = satb_ff | ovf32(s);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff     <= n_in;
         tpa_ff   <= in_side.tp;
         sata_ff  <= in_side.sat;
         zeroa_ff <= in_side.zero;
         prod_ff  <= prod_in;
         nb_ff    <= n_ff[0:2];
         satb_ff  <= sata_ff;
         zerob_ff <= zeroa_ff;
      end
   end

   assign push = en && vb_ff;
   assign take = out_valid_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff         <= 1'b0;
         vb_ff         <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            va_ff <= in_valid;
            vb_ff <= va_ff;
         end
         if (skid_valid_ff) begin
            // drain the skid slot once the output is taken
            if (take) begin
               skid_valid_ff <= 1'b0;
            end
         end else if (!out_valid_ff || take) begin
            out_valid_ff <= push;
         end else if (push) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (!out_valid_ff || take) begin
         out_ff <= item_in;
      end else begin
         skid_ff <= item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

@@ sv/plane_rigid_transform.sv @@
// Top level of the plane rigid transform: matrix registers and pipeline.
// Depends on prt_pkg, prt_xform, prt_sqrt, prt_div, prt_out.
//
//   channel  ports                           role
//   req      req_valid req_ready req_data    plane in (a, b, c, d)
//   rsp      rsp_valid rsp_ready rsp_data    transformed plane and flags
//   csr      csr_valid csr_ready csr_index   matrix register write
//            csr_data
//
// One item per cycle sustained while the output is not stalled; 56 register stages,
// among them the 32 root stages and the 17 quotient stages of the normalize path.
// Reset (synchronous) clears all valid bits and loads the default matrix.
// A stalled output holds in the output register; one more item lands in the
// skid slot, then req_ready drops until the slot drains. csr_ready is always high.
`default_nettype none

module plane_rigid_transform #(
   parameter int COEF_WIDTH = prt_pkg::COEF_WIDTH_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  prt_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output prt_pkg::rsp_type                rsp_data,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire  [prt_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire  [63:0]                     csr_data
);
   import prt_pkg::*;

   logic [63:0]                 regs_ff [REG_COUNT];
   logic [3:0][3:0][COEF_WIDTH-1:0] coef;
   logic                        en;
   logic                        x_valid, s_valid, d_valid;
   logic [63:0]                 x_len2;
   logic [31:0]                 s_len;
   logic [2:0][16:0]            d_quot;
   side_type                    x_side, s_side, d_side;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REG_RESET;
      end else if (csr_valid && csr_index < CSR_INDEX_WIDTH'(REG_COUNT)) begin
         // drop writes beyond the register list
         regs_ff[csr_index[REG_SEL_WIDTH-1:0]] <= csr_data;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            coef[r][c] = regs_ff[REG_SEL_WIDTH'(r * 2 + c / 2)][32 * (c % 2) +: COEF_WIDTH];
         end
      end
   end

   assign req_ready = en;

   prt_xform #(
      .COEF_WIDTH (COEF_WIDTH)
   ) u_xform (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid && req_ready),
      .in_data   (req_data),
      .coef      (coef),
      .out_valid (x_valid),
      .out_len2  (x_len2),
      .out_side  (x_side)
   );

   prt_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (x_valid),
      .in_len2   (x_len2),
      .in_side   (x_side),
      .out_valid (s_valid),
      .out_len   (s_len),
      .out_side  (s_side)
   );

   prt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s_valid),
      .in_len    (s_len),
      .in_side   (s_side),
      .out_valid (d_valid),
      .out_quot  (d_quot),
      .out_side  (d_side)
   );

   prt_out u_out (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_quot   (d_quot),
      .in_side   (d_side),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
